FILE: hdl/bsct_pkg.sv
// Shared types and constants for the BCD up/down timer.
package bsct_pkg;

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_RESET  = 3'd1,
      MODE_PAUSE  = 3'd2,
      MODE_RESUME = 3'd3,
      MODE_TOGGLE = 3'd4,
      MODE_ADJUST = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      SEL_SEC_UNITS  = 3'd0,
      SEL_SEC_TENS   = 3'd1,
      SEL_MIN_UNITS  = 3'd2,
      SEL_MIN_TENS   = 3'd3,
      SEL_HOUR_UNITS = 3'd4,
      SEL_HOUR_TENS  = 3'd5
   } digit_sel_type;

   localparam logic [3:0] UNITS_MAX     = 4'd9;
   localparam logic [2:0] MS_TENS_MAX   = 3'd5;
   localparam logic [3:0] HOUR_TENS_MAX = 4'd9;

   typedef struct packed {
      logic [3:0] hour_tens;
      logic [3:0] hour_units;
      logic [2:0] min_tens;
      logic [3:0] min_units;
      logic [2:0] sec_tens;
      logic [3:0] sec_units;
   } count_type;

endpackage

FILE: hdl/bcd_stopwatch_countdown_timer_unit.sv
// Top level of the BCD HH:MM:SS up/down timer with alarm.
//
// One event beat is taken per clock while req_stall is low. Its result beat (the full timer state
// after the event) appears on the rsp_ side on the cycle after acceptance; the state registers
// themselves are the result register, so the next event is taken in that same cycle unless
// the result is stalled. req_stall rises only while a result is held and rsp_stall is high.
// Sustained rate: one event per cycle while rsp_stall is low, set by the single register stage
// holding the digits and flags.
module bcd_stopwatch_countdown_timer_unit
   import bsct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_mode,
   input  logic [2:0] req_digit_select,
   input  logic       req_adjust_up,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_sec_units,
   output logic [2:0] rsp_sec_tens,
   output logic [3:0] rsp_min_units,
   output logic [2:0] rsp_min_tens,
   output logic [3:0] rsp_hour_units,
   output logic [3:0] rsp_hour_tens,
   output logic       rsp_counting_down,
   output logic       rsp_is_running,
   output logic       rsp_timeout_alarm
);

   count_type count_ff, count_in;
   logic      down_ff, down_in;
   logic      run_ff, run_in;
   logic      armed_ff, armed_in;
   logic      alarm_ff, alarm_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   function automatic logic is_zero(input count_type c);
      is_zero = (c == '0);
   endfunction

   function automatic count_type tick_up(input count_type c);
      count_type r;
      r = c;
      if (c.sec_units < UNITS_MAX) r.sec_units = c.sec_units + 4'd1;
      else begin
         r.sec_units = '0;
         if (c.sec_tens < MS_TENS_MAX) r.sec_tens = c.sec_tens + 3'd1;
         else begin
            r.sec_tens = '0;
            if (c.min_units < UNITS_MAX) r.min_units = c.min_units + 4'd1;
            else begin
               r.min_units = '0;
               if (c.min_tens < MS_TENS_MAX) r.min_tens = c.min_tens + 3'd1;
               else begin
                  r.min_tens = '0;
                  if (c.hour_units < UNITS_MAX) r.hour_units = c.hour_units + 4'd1;
                  else begin
                     r.hour_units = '0;
                     if (c.hour_tens < HOUR_TENS_MAX) r.hour_tens = c.hour_tens + 4'd1;
                     else r.hour_tens = '0;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // caller guards the all-zero count
   function automatic count_type tick_down(input count_type c);
      count_type r;
      r = c;
      if (c.sec_units != '0) r.sec_units = c.sec_units - 4'd1;
      else begin
         r.sec_units = UNITS_MAX;
         if (c.sec_tens != '0) r.sec_tens = c.sec_tens - 3'd1;
         else begin
            r.sec_tens = MS_TENS_MAX;
            if (c.min_units != '0) r.min_units = c.min_units - 4'd1;
            else begin
               r.min_units = UNITS_MAX;
               if (c.min_tens != '0) r.min_tens = c.min_tens - 3'd1;
               else begin
                  r.min_tens = MS_TENS_MAX;
                  if (c.hour_units != '0) r.hour_units = c.hour_units - 4'd1;
                  else begin
                     r.hour_units = UNITS_MAX;
                     if (c.hour_tens != '0) r.hour_tens = c.hour_tens - 4'd1;
                     else r.hour_tens = HOUR_TENS_MAX;
                  end
               end
            end
         end
      end
      return r;
   endfunction

   // units adjust with carry/borrow into tens; returns {tens, units}
   function automatic logic [7:0] adjust_pair(input logic [3:0] u, input logic [3:0] t,
                                              input logic [3:0] tmax, input logic up);
      logic [3:0] nu;
      logic [3:0] nt;
      nu = u;
      nt = t;
      if (up) begin
         if (u < UNITS_MAX) nu = u + 4'd1;
         else if (t < tmax) begin
            nu = '0;
            nt = t + 4'd1;
         end
      end else begin
         if (u != '0) nu = u - 4'd1;
         else if (t != '0) begin
            nt = t - 4'd1;
            nu = UNITS_MAX;
         end
      end
      return {nt, nu};
   endfunction

   function automatic logic [3:0] adjust_single(input logic [3:0] t, input logic [3:0] tmax,
                                                input logic up);
      logic [3:0] nt;
      nt = t;
      if (up) begin
         if (t < tmax) nt = t + 4'd1;
      end else if (t != '0) nt = t - 4'd1;
      return nt;
   endfunction

   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign req_accept   = req_valid & ~req_stall;
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_comb begin
      logic [7:0] pair;
      count_in = count_ff;
      down_in  = down_ff;
      run_in   = run_ff;
      armed_in = armed_ff;
      alarm_in = alarm_ff;
      pair     = '0;
      case (req_mode)
         MODE_TICK: begin
            if (run_ff) begin
               if (!down_ff) begin
                  armed_in = 1'b1;
                  count_in = tick_up(count_ff);
               end else begin
                  if (!is_zero(count_ff)) count_in = tick_down(count_ff);
                  if (is_zero(count_in) && armed_ff) alarm_in = 1'b1;
               end
            end
         end
         MODE_RESET: begin
            count_in = '0;
            armed_in = 1'b0;
            alarm_in = 1'b0;
         end
         MODE_PAUSE:  run_in = 1'b0;
         MODE_RESUME: run_in = 1'b1;
         MODE_TOGGLE: begin
            down_in = ~down_ff;
            if (down_ff) alarm_in = 1'b0;
         end
         MODE_ADJUST: begin
            case (req_digit_select)
               SEL_SEC_UNITS: begin
                  pair = adjust_pair(count_ff.sec_units, {1'b0, count_ff.sec_tens},
                                     {1'b0, MS_TENS_MAX}, req_adjust_up);
                  count_in.sec_units = pair[3:0];
                  count_in.sec_tens  = pair[6:4];
               end
               SEL_SEC_TENS: begin
                  pair[3:0] = adjust_single({1'b0, count_ff.sec_tens}, {1'b0, MS_TENS_MAX},
                                            req_adjust_up);
                  count_in.sec_tens = pair[2:0];
               end
               SEL_MIN_UNITS: begin
                  pair = adjust_pair(count_ff.min_units, {1'b0, count_ff.min_tens},
                                     {1'b0, MS_TENS_MAX}, req_adjust_up);
                  count_in.min_units = pair[3:0];
                  count_in.min_tens  = pair[6:4];
               end
               SEL_MIN_TENS: begin
                  pair[3:0] = adjust_single({1'b0, count_ff.min_tens}, {1'b0, MS_TENS_MAX},
                                            req_adjust_up);
                  count_in.min_tens = pair[2:0];
               end
               SEL_HOUR_UNITS: begin
                  pair = adjust_pair(count_ff.hour_units, count_ff.hour_tens,
                                     HOUR_TENS_MAX, req_adjust_up);
                  count_in.hour_units = pair[3:0];
                  count_in.hour_tens  = pair[7:4];
               end
               SEL_HOUR_TENS: begin
                  count_in.hour_tens = adjust_single(count_ff.hour_tens, HOUR_TENS_MAX,
                                                     req_adjust_up);
               end
               default: ;
            endcase
            if (req_adjust_up && (req_digit_select <= SEL_HOUR_TENS)) armed_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         down_ff      <= 1'b0;
         run_ff       <= 1'b1;
         armed_ff     <= 1'b1;
         alarm_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            count_ff <= count_in;
            down_ff  <= down_in;
            run_ff   <= run_in;
            armed_ff <= armed_in;
            alarm_ff <= alarm_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sec_units     = count_ff.sec_units;
   assign rsp_sec_tens      = count_ff.sec_tens;
   assign rsp_min_units     = count_ff.min_units;
   assign rsp_min_tens      = count_ff.min_tens;
   assign rsp_hour_units    = count_ff.hour_units;
   assign rsp_hour_tens     = count_ff.hour_tens;
   assign rsp_counting_down = down_ff;
   assign rsp_is_running    = run_ff;
   assign rsp_timeout_alarm = alarm_ff;

`ifndef SYNTHESIS
   a_stall_needs_held_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with no held result beat");

   a_alarm_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(alarm_ff) |-> $past(req_accept && (req_mode == MODE_TICK) && down_ff))
      else $error("alarm raised without a countdown tick");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(req_accept)) |-> $stable(count_ff) && $stable(alarm_ff))
      else $error("timer state changed without an accepted beat");

   a_count_legal: assert property (@(posedge clock) disable iff (reset)
      (count_ff.sec_units <= UNITS_MAX) && (count_ff.sec_tens <= MS_TENS_MAX) &&
      (count_ff.min_units <= UNITS_MAX) && (count_ff.min_tens <= MS_TENS_MAX) &&
      (count_ff.hour_units <= UNITS_MAX) && (count_ff.hour_tens <= HOUR_TENS_MAX))
      else $error("BCD digit out of range");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the BCD HH:MM:SS up/down timer with alarm.

import bsct_pkg::*;

typedef struct packed {
   count_type count;
   logic      counting_down;
   logic      is_running;
   logic      timeout_alarm;
} timer_result_type;

class timer_state_checker;
   logic [3:0]       digit [6];
   logic [3:0]       limit [6];
   bit               down;
   bit               run;
   bit               armed;
   bit               alarm;
   int               errors;
   timer_result_type expected_states[$];

   function new();
      limit[0] = UNITS_MAX;
      limit[1] = 4'(MS_TENS_MAX);
      limit[2] = UNITS_MAX;
      limit[3] = 4'(MS_TENS_MAX);
      limit[4] = UNITS_MAX;
      limit[5] = HOUR_TENS_MAX;
      for (int i = 0; i < 6; i++) digit[i] = 4'd0;
      down   = 1'b0;
      run    = 1'b1;
      armed  = 1'b1;
      alarm  = 1'b0;
      errors = 0;
   endfunction

   function bit count_zero();
      bit z;
      z = 1'b1;
      for (int i = 0; i < 6; i++) if (digit[i] != 4'd0) z = 1'b0;
      return z;
   endfunction

   function void step_second_up();
      bit carry;
      carry = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (carry) begin
            if (digit[i] >= limit[i]) begin
               digit[i] = 4'd0;
            end else begin
               digit[i] = digit[i] + 4'd1;
               carry = 1'b0;
            end
         end
      end
   endfunction

   function void step_second_down();
      bit borrow;
      borrow = 1'b1;
      if (count_zero()) return;
      for (int i = 0; i < 6; i++) begin
         if (borrow) begin
            if (digit[i] == 4'd0) begin
               digit[i] = limit[i];
            end else begin
               digit[i] = digit[i] - 4'd1;
               borrow = 1'b0;
            end
         end
      end
   endfunction

   function void adjust_digit(int sel, bit up);
      int t;
      if (sel == SEL_SEC_UNITS || sel == SEL_MIN_UNITS || sel == SEL_HOUR_UNITS) begin
         t = sel + 1;
         if (up) begin
            if (digit[sel] < UNITS_MAX) begin
               digit[sel] = digit[sel] + 4'd1;
            end else if (digit[t] < limit[t]) begin
               digit[sel] = 4'd0;
               digit[t]   = digit[t] + 4'd1;
            end
         end else begin
            if (digit[sel] != 4'd0) begin
               digit[sel] = digit[sel] - 4'd1;
            end else if (digit[t] != 4'd0) begin
               digit[t]   = digit[t] - 4'd1;
               digit[sel] = UNITS_MAX;
            end
         end
      end else begin
         if (up) begin
            if (digit[sel] < limit[sel]) digit[sel] = digit[sel] + 4'd1;
         end else if (digit[sel] != 4'd0) begin
            digit[sel] = digit[sel] - 4'd1;
         end
      end
   endfunction

   function void apply_event(logic [2:0] mode, logic [2:0] sel, logic up);
      timer_result_type r;
      case (mode)
         MODE_TICK: begin
            if (run) begin
               if (!down) begin
                  armed = 1'b1;
                  step_second_up();
               end else begin
                  step_second_down();
                  if (count_zero() && armed) alarm = 1'b1;
               end
            end
         end
         MODE_RESET: begin
            for (int i = 0; i < 6; i++) digit[i] = 4'd0;
            armed = 1'b0;
            alarm = 1'b0;
         end
         MODE_PAUSE:  run = 1'b0;
         MODE_RESUME: run = 1'b1;
         MODE_TOGGLE: begin
            down = !down;
            if (!down) alarm = 1'b0;
         end
         MODE_ADJUST: begin
            if (sel <= SEL_HOUR_TENS) begin
               adjust_digit(int'(sel), up);
               if (up) armed = 1'b1;
            end
         end
         default: ;
      endcase
      r.count.sec_units  = digit[0];
      r.count.sec_tens   = digit[1][2:0];
      r.count.min_units  = digit[2];
      r.count.min_tens   = digit[3][2:0];
      r.count.hour_units = digit[4];
      r.count.hour_tens  = digit[5];
      r.counting_down    = down;
      r.is_running       = run;
      r.timeout_alarm    = alarm;
      expected_states.push_back(r);
   endfunction

   function void compare_field(string name, int expv, int actv);
      if (expv != actv) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      end
   endfunction

   function void check_state(timer_result_type got);
      timer_result_type e;
      if (expected_states.size() == 0) begin
         errors++;
         $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
         return;
      end
      e = expected_states.pop_front();
      compare_field("sec_units",     e.count.sec_units,  got.count.sec_units);
      compare_field("sec_tens",      e.count.sec_tens,   got.count.sec_tens);
      compare_field("min_units",     e.count.min_units,  got.count.min_units);
      compare_field("min_tens",      e.count.min_tens,   got.count.min_tens);
      compare_field("hour_units",    e.count.hour_units, got.count.hour_units);
      compare_field("hour_tens",     e.count.hour_tens,  got.count.hour_tens);
      compare_field("counting_down", e.counting_down,    got.counting_down);
      compare_field("is_running",    e.is_running,       got.is_running);
      compare_field("timeout_alarm", e.timeout_alarm,    got.timeout_alarm);
   endfunction

   function int pending();
      return expected_states.size();
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_EVENTS = 500;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_mode;
   logic [2:0] req_digit_select;
   logic       req_adjust_up;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_sec_units;
   logic [2:0] rsp_sec_tens;
   logic [3:0] rsp_min_units;
   logic [2:0] rsp_min_tens;
   logic [3:0] rsp_hour_units;
   logic [3:0] rsp_hour_tens;
   logic       rsp_counting_down;
   logic       rsp_is_running;
   logic       rsp_timeout_alarm;

   timer_state_checker sb;
   int req_gap_max = 6;
   int rsp_gap_max = 6;
   int events_sent = 0;
   int rsp_beats = 0;
   int rsp_seen = 0;
   int rsp_hold = 0;
   int cycle_count = 0;

   bcd_stopwatch_countdown_timer_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_digit_select  (req_digit_select),
      .req_adjust_up     (req_adjust_up),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sec_units     (rsp_sec_units),
      .rsp_sec_tens      (rsp_sec_tens),
      .rsp_min_units     (rsp_min_units),
      .rsp_min_tens      (rsp_min_tens),
      .rsp_hour_units    (rsp_hour_units),
      .rsp_hour_tens     (rsp_hour_tens),
      .rsp_counting_down (rsp_counting_down),
      .rsp_is_running    (rsp_is_running),
      .rsp_timeout_alarm (rsp_timeout_alarm)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      timer_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.apply_event(req_mode, req_digit_select, req_adjust_up);
         if (rsp_valid && !rsp_stall) begin
            got.count.sec_units  = rsp_sec_units;
            got.count.sec_tens   = rsp_sec_tens;
            got.count.min_units  = rsp_min_units;
            got.count.min_tens   = rsp_min_tens;
            got.count.hour_units = rsp_hour_units;
            got.count.hour_tens  = rsp_hour_tens;
            got.counting_down    = rsp_counting_down;
            got.is_running       = rsp_is_running;
            got.timeout_alarm    = rsp_timeout_alarm;
            sb.check_state(got);
            rsp_beats++;
         end
      end
   end

   // result side: fresh stall draw after every accepted beat
   always @(negedge clock) begin
      if (rsp_beats != rsp_seen) begin
         rsp_seen = rsp_beats;
         rsp_hold = $urandom_range(0, rsp_gap_max);
      end
      if (rsp_hold > 0) begin
         rsp_stall = 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   task automatic drive_event(input logic [2:0] mode, input logic [2:0] sel, input logic up);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_mode         = mode;
      req_digit_select = sel;
      req_adjust_up    = up;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      events_sent++;
   endtask

   task automatic send_op(input logic [2:0] mode);
      drive_event(mode, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_tick();
      if ($urandom_range(0, 15) == 0) begin
         send_op(MODE_PAUSE);
         send_op(MODE_TICK);
         send_op(MODE_RESUME);
      end else begin
         send_op(MODE_TICK);
      end
   endtask

   task automatic count_down_run();
      int n;
      n = 0;
      if ($urandom_range(0, 1) == 1) send_op(MODE_RESET);
      if (!sb.down) send_op(MODE_TOGGLE);
      if (!sb.run) send_op(MODE_RESUME);
      repeat ($urandom_range(1, 4))
         drive_event(MODE_ADJUST, 3'($urandom_range(0, 1)), 1'($urandom_range(0, 3) != 0));
      while (!sb.count_zero() && n < 70) begin
         send_tick();
         n++;
      end
      repeat ($urandom_range(0, 2)) send_op(MODE_TICK);
   endtask

   task automatic count_up_run();
      if (sb.down) send_op(MODE_TOGGLE);
      if (!sb.run) send_op(MODE_RESUME);
      repeat ($urandom_range(0, 3))
         drive_event(MODE_ADJUST, 3'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(5, 30)) send_tick();
   endtask

   task automatic fill_and_wrap();
      send_op(MODE_RESET);
      if (sb.down) send_op(MODE_TOGGLE);
      if (!sb.run) send_op(MODE_RESUME);
      for (int i = 0; i < 6; i++)
         repeat (int'(sb.limit[i])) drive_event(MODE_ADJUST, 3'(i), 1'b1);
      drive_event(MODE_ADJUST, SEL_SEC_UNITS, 1'b1);
      drive_event(MODE_ADJUST, SEL_HOUR_UNITS, 1'b1);
      if ($urandom_range(0, 1) == 1) begin
         send_op(MODE_TOGGLE);
         repeat (3) send_op(MODE_TICK);
         send_op(MODE_TOGGLE);
      end
      repeat (3) send_op(MODE_TICK);
   endtask

   initial begin
      int pick;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_TICK;
      req_digit_select = SEL_SEC_UNITS;
      req_adjust_up    = 1'b0;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      drive_event(MODE_TICK, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_ADJUST, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_ADJUST, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_ADJUST, SEL_SEC_TENS, 1'b0);
      drive_event(MODE_ADJUST, SEL_HOUR_UNITS, 1'b1);
      drive_event(MODE_TOGGLE, 3'd7, 1'b1);
      drive_event(MODE_TICK, 3'd6, 1'b0);
      drive_event(MODE_ADJUST, SEL_SEC_UNITS, 1'b1);
      drive_event(MODE_ADJUST, SEL_SEC_TENS, 1'b1);
      drive_event(MODE_ADJUST, SEL_MIN_UNITS, 1'b1);
      drive_event(MODE_ADJUST, SEL_MIN_TENS, 1'b1);
      drive_event(MODE_RESET, SEL_HOUR_TENS, 1'b1);
      drive_event(MODE_TICK, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_ADJUST, SEL_SEC_UNITS, 1'b1);
      drive_event(MODE_TICK, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_TICK, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_PAUSE, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_TICK, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_RESUME, SEL_SEC_UNITS, 1'b0);
      drive_event(MODE_TOGGLE, SEL_SEC_UNITS, 1'b0);
      drive_event(3'd6, 3'd7, 1'b1);
      drive_event(3'd7, 3'd0, 1'b0);
      drive_event(MODE_ADJUST, 3'd6, 1'b1);
      drive_event(MODE_ADJUST, 3'd7, 1'b0);
      drive_event(MODE_ADJUST, SEL_HOUR_TENS, 1'b1);
      drive_event(MODE_ADJUST, SEL_HOUR_UNITS, 1'b0);
      drive_event(MODE_ADJUST, SEL_HOUR_TENS, 1'b0);

      while (events_sent < RANDOM_EVENTS + 27) begin
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            fill_and_wrap();
         end else if (pick < 7) begin
            count_down_run();
         end else if (pick < 13) begin
            count_up_run();
         end else begin
            repeat ($urandom_range(3, 12))
               drive_event(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                           1'($urandom_range(0, 1)));
         end
      end

      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
